FILE: design/ils_pkg.sv
// Shared types, constants and helpers for the integer list sorter.
package ils_pkg;

	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_RD    = 6'b000010,
		S_CMP   = 6'b000100,
		S_EM_RD = 6'b001000,
		S_EM_LD = 6'b010000,
		S_EM_WT = 6'b100000
	} state_t;

	function automatic logic ils_gt(input data_t a, input data_t b);
		return a > b;
	endfunction

endpackage

FILE: design/ils_if.sv
// Valid/ready channel interfaces for the sorter input and output items.
interface ils_in_if import ils_pkg::*;;
	logic  valid;
	logic  ready;
	data_t value;
	logic  final_req;

	modport source (output valid, output value, output final_req, input ready);
	modport sink (input valid, input value, input final_req, output ready);
endinterface

interface ils_out_if import ils_pkg::*;;
	logic  valid;
	logic  ready;
	data_t sorted_value;
	logic  last;
	logic  overflow;

	modport source (output valid, output sorted_value, output last, output overflow,
		input ready);
	modport sink (input valid, input sorted_value, input last, input overflow,
		output ready);
endinterface

FILE: design/ils_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ils_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/ils_ctrl.sv
// Sequencer that inserts items into the sorted store and streams the run out.
module ils_ctrl import ils_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ils_in_if.sink                      in_ch,
	ils_out_if.source                   out_ch,
	output logic                        ram_we,
	output logic [$clog2(CAPACITY)-1:0] ram_waddr,
	output data_t                       ram_wdata,
	output logic [$clog2(CAPACITY)-1:0] ram_raddr,
	input  data_t                       ram_rdata
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic          flag_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] k_q;
	data_t         val_q;
	logic          final_q;
	logic          out_valid_q;
	data_t         sorted_q;
	logic          last_q;
	logic          ovf_q;
	logic          greater;

	assign greater = ils_gt(ram_rdata, val_q);

	assign in_ch.ready         = (state_q == S_IDLE);
	assign out_ch.valid        = out_valid_q;
	assign out_ch.sorted_value = sorted_q;
	assign out_ch.last         = last_q;
	assign out_ch.overflow     = ovf_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = val_q;
		ram_raddr = idx_q - AW'(1);
		unique case (state_q)
			S_RD: begin
				if (idx_q == '0) begin
					ram_we = 1'b1;
				end
			end
			S_CMP: begin
				ram_we = 1'b1;
				if (greater) begin
					ram_wdata = ram_rdata;
				end
			end
			S_EM_RD: begin
				ram_raddr = k_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			k_q         <= '0;
			val_q       <= '0;
			final_q     <= 1'b0;
			sorted_q    <= '0;
			last_q      <= 1'b0;
			ovf_q       <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						k_q <= '0;
						if (count_q == CW'(CAPACITY)) begin
							flag_q <= 1'b1;
							if (in_ch.final_req) begin
								state_q <= S_EM_RD;
							end
						end else begin
							val_q   <= in_ch.value;
							final_q <= in_ch.final_req;
							idx_q   <= count_q[AW-1:0];
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					if (idx_q == '0) begin
						count_q <= count_q + CW'(1);
						state_q <= final_q ? S_EM_RD : S_IDLE;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (greater) begin
						idx_q   <= idx_q - AW'(1);
						state_q <= S_RD;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= final_q ? S_EM_RD : S_IDLE;
					end
				end
				S_EM_RD: begin
					state_q <= S_EM_LD;
				end
				S_EM_LD: begin
					sorted_q    <= ram_rdata;
					last_q      <= (CW'(k_q) + CW'(1)) == count_q;
					ovf_q       <= flag_q;
					out_valid_q <= 1'b1;
					state_q     <= S_EM_WT;
				end
				S_EM_WT: begin
					if (out_ch.ready) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							count_q <= '0;
							flag_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= S_EM_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: design/integer_list_sorter_top.sv
// An accepted item walks down from the end of the store: each held value greater than it is read
// (S_RD), compared (S_CMP) and moved up one place, and the item is written where the walk stops.
// An item that arrives while the store is full is dropped. After the final item the run follows,
// the next result only once the sink has taken the last; input ready is low throughout insertion
// and emission. Reset clears the fill count and the overflow flag; the store itself is not cleared,
// and there is no clearing pass, so the block is ready right after reset.
module integer_list_sorter_top import ils_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	ils_in_if.sink    in_ch,
	ils_out_if.source out_ch
);

	localparam int AW = $clog2(CAPACITY);

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	data_t         ram_wdata;
	logic [AW-1:0] ram_raddr;
	data_t         ram_rdata;

	ils_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	ils_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
